/* hw/rtl/pscd_pkg.sv */
// pscd_pkg: shared types and constants for the pot scan calibrate / change detect block
// word structs, configuration register indexes, sequencer states
// no dependencies
`timescale 1ns / 1ps

package pscd_pkg;

    localparam int CHAN_W    = 4;
    localparam int VALUE_W   = 10;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_STEPS = 10;
    localparam int CNT_W     = 4;

    localparam logic [VALUE_W-1:0] VALUE_MAX     = 10'd1023;
    localparam logic [VALUE_W-1:0] SENS_RESET    = 10'd8;
    localparam logic [VALUE_W-1:0] CAL_LOW_RESET = 10'd0;

    // input word
    typedef struct packed {
        logic [CHAN_W-1:0]  scan_channel;
        logic [VALUE_W-1:0] raw_sample;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [CHAN_W-1:0]  channel_out;
        logic [VALUE_W-1:0] value_out;
        logic               changed;
    } t_out_word;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SENSITIVITY = 2'd0,
        CFG_CAL_LOW     = 2'd1,
        CFG_CAL_HIGH    = 2'd2
    } t_cfg_idx;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_CHECK
    } t_state;

endpackage

/* hw/rtl/pot_scan_calibrate_change_detect.sv */
// pot_scan_calibrate_change_detect: slider calibration and deadband change detection
// for a multiplexed 10-bit converter scan, one sequential restoring divider inside
// depends on pscd_pkg
`timescale 1ns / 1ps

// Usage
//   input channel: i_in_valid / o_in_ready carry one word (scan channel, raw sample)
//   output channel: o_out_valid / i_out_ready carry one word (channel, value, changed)
//   config port: i_cfg_we writes i_cfg_data to register i_cfg_idx
//     (0 sensitivity, 1 slider low point, 2 slider high point); write only while idle, not enforced by the block
// Flow
//   a slider word that needs the divider goes through a setup state, ten restoring
//   division steps on the shared subtract/compare unit and a check state
//   other channels, and slider words that clamp or have equal calibration points,
//   skip the divider and go from the setup state straight to the check state
//   one word is in work at a time; the next is taken once the block is back idle
// Reset
//   registers return to sensitivity 8, low point 0, high point 1023, and every
//   last reported value clears to zero; no clearing pass is needed
// Stall
//   the result sits in an output register; a new word is still taken and worked
//   on, and waits in the check cycle until the held result is taken
module pot_scan_calibrate_change_detect #(
    parameter int NUM_CHANNELS = 16,
    parameter int SLIDER_COUNT = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  pscd_pkg::t_in_word                i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output pscd_pkg::t_out_word               o_out,
    input  logic                              i_cfg_we,
    input  logic [pscd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pscd_pkg::VALUE_W-1:0]      i_cfg_data
);

    localparam int CHAN_SPAN = 1 << pscd_pkg::CHAN_W;
    localparam int DEPTH     = (NUM_CHANNELS < CHAN_SPAN) ? NUM_CHANNELS : CHAN_SPAN;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // configuration registers
    logic [pscd_pkg::VALUE_W-1:0] r_sens;
    logic [pscd_pkg::VALUE_W-1:0] r_cal_low;
    logic [pscd_pkg::VALUE_W-1:0] r_cal_high;

    // sequencer and working registers
    pscd_pkg::t_state             r_state, n_state;
    logic [pscd_pkg::CHAN_W-1:0]  r_ch;
    logic [pscd_pkg::VALUE_W-1:0] r_raw;
    logic                         r_zero;
    logic                         r_ovf;
    logic [pscd_pkg::VALUE_W-1:0] r_rem;
    logic [pscd_pkg::VALUE_W-1:0] r_quo;
    logic [pscd_pkg::VALUE_W-1:0] r_dsr;
    logic [pscd_pkg::CNT_W-1:0]   r_cnt;

    // last reported values
    logic [pscd_pkg::VALUE_W-1:0] r_last [DEPTH];

    // output register
    logic                         r_out_valid;
    pscd_pkg::t_out_word          r_out;

    logic w_accept;
    logic w_commit;
    logic w_slider;
    logic w_stored;

    // config writes, unknown index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens     <= pscd_pkg::SENS_RESET;
            r_cal_low  <= pscd_pkg::CAL_LOW_RESET;
            r_cal_high <= pscd_pkg::VALUE_MAX;
        end else if (i_cfg_we) begin
            case (pscd_pkg::t_cfg_idx'(i_cfg_idx))
                pscd_pkg::CFG_SENSITIVITY: r_sens     <= i_cfg_data;
                pscd_pkg::CFG_CAL_LOW:     r_cal_low  <= i_cfg_data;
                pscd_pkg::CFG_CAL_HIGH:    r_cal_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // channel classes
    assign w_slider = ({1'b0, r_ch} < 5'(SLIDER_COUNT));
    assign w_stored = ({3'b000, r_ch} < 7'(NUM_CHANNELS));

    // setup: offset times 1023 and span, signs, overflow check
    logic signed [10:0] w_off;
    logic signed [10:0] w_span;
    logic [20:0]        w_off_ext;
    logic [20:0]        w_num;
    logic [20:0]        w_num_neg;
    logic [19:0]        w_num_mag;
    logic [10:0]        w_span_neg;
    logic [9:0]         w_span_mag;
    logic               w_zero;
    logic               w_ovf;

    always_comb begin
        w_off      = $signed({1'b0, r_raw}) - $signed({1'b0, r_cal_low});
        w_span     = $signed({1'b0, r_cal_high}) - $signed({1'b0, r_cal_low});
        w_off_ext  = {{10{w_off[10]}}, w_off};
        w_num      = (w_off_ext << 10) - w_off_ext;
        w_num_neg  = 21'd0 - w_num;
        w_num_mag  = w_num[20] ? w_num_neg[19:0] : w_num[19:0];
        w_span_neg = 11'd0 - w_span;
        w_span_mag = w_span[10] ? w_span_neg[9:0] : w_span[9:0];
        // negative quotient truncates to zero or below, clamps to zero
        w_zero     = (w_span == 11'sd0) || ((w_num[20] != w_span[10]) && (w_num != 21'd0));
        w_ovf      = (w_num_mag[19:10] >= w_span_mag);
    end

    // shared subtract/compare unit: one restoring division step
    logic [11:0] w_trial;
    logic        w_fits;

    always_comb begin
        w_trial = {1'b0, r_rem, r_quo[9]} - {2'b00, r_dsr};
        w_fits  = !w_trial[11];
    end

    // conditioned value and deadband check
    logic [pscd_pkg::VALUE_W-1:0] w_val;
    logic [pscd_pkg::VALUE_W-1:0] w_prev;
    logic [pscd_pkg::VALUE_W-1:0] w_diff;
    logic [ADDR_W-1:0]            w_addr;
    logic                         w_changed;

    always_comb begin
        if (!w_slider) begin
            w_val = r_raw;
        end else if (r_zero) begin
            w_val = '0;
        end else if (r_ovf) begin
            w_val = pscd_pkg::VALUE_MAX;
        end else begin
            w_val = r_quo;
        end
        w_addr    = r_ch[ADDR_W-1:0];
        w_prev    = r_last[w_addr];
        w_diff    = (w_val > w_prev) ? (w_val - w_prev) : (w_prev - w_val);
        w_changed = w_stored && (w_diff > r_sens);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pscd_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = pscd_pkg::ST_PREP;
            end
            pscd_pkg::ST_PREP: begin
                if (w_slider && (w_span != 11'sd0) && !w_zero && !w_ovf) begin
                    n_state = pscd_pkg::ST_DIV;
                end else begin
                    n_state = pscd_pkg::ST_CHECK;
                end
            end
            pscd_pkg::ST_DIV: begin
                if (r_cnt == pscd_pkg::CNT_W'(pscd_pkg::DIV_STEPS - 1)) begin
                    n_state = pscd_pkg::ST_CHECK;
                end
            end
            pscd_pkg::ST_CHECK: begin
                if (!r_out_valid || i_out_ready) n_state = pscd_pkg::ST_IDLE;
            end
            default: n_state = pscd_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_commit   = 1'b0;
        case (r_state)
            pscd_pkg::ST_IDLE:  o_in_ready = 1'b1;
            pscd_pkg::ST_CHECK: w_commit   = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    assign w_accept = i_in_valid && o_in_ready;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pscd_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == pscd_pkg::ST_DIV) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ch  <= i_in.scan_channel;
            r_raw <= i_in.raw_sample;
        end
        case (r_state)
            pscd_pkg::ST_PREP: begin
                r_zero <= w_zero;
                r_ovf  <= w_ovf;
                r_rem  <= w_num_mag[19:10];
                r_quo  <= w_num_mag[9:0];
                r_dsr  <= w_span_mag;
            end
            pscd_pkg::ST_DIV: begin
                r_rem <= w_fits ? w_trial[9:0] : {r_rem[8:0], r_quo[9]};
                r_quo <= {r_quo[8:0], w_fits};
            end
            default: ;
        endcase
        if (w_commit) begin
            r_out.channel_out <= r_ch;
            r_out.value_out   <= w_val;
            r_out.changed     <= w_changed;
        end
    end

    // last reported value store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_last[i] <= '0;
            end
        end else if (w_commit && w_changed) begin
            r_last[w_addr] <= w_val;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // an accepted word always starts with the setup cycle
    a_accept_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == pscd_pkg::ST_PREP))
        else $error("accepted word did not enter setup");

    // division step count stays within the quotient width
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pscd_pkg::ST_DIV) |-> (r_cnt < pscd_pkg::CNT_W'(pscd_pkg::DIV_STEPS)))
        else $error("division ran past its step count");

    // leaving the check cycle leaves a result in the output register
    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> r_out_valid)
        else $error("committed result not presented");

    // a held changed result matches the latched value for its channel
    a_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.changed) |->
            (r_last[r_out.channel_out[ADDR_W-1:0]] == r_out.value_out))
        else $error("changed result not latched");

endmodule
